FILE: rtl/fsc_pkg.sv
`timescale 1ns / 1ps
package fsc_pkg;

  localparam int FSC_FRAC_BITS = 16;
  localparam int NUM_PLANES = 6;

  localparam logic [2:0] PLANE_NONE = 3'd6;
  localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

  localparam logic [1:0] OP_VIEW = 2'd0;
  localparam logic [1:0] OP_PROJ = 2'd1;
  localparam logic [1:0] OP_TEST = 2'd2;

  localparam logic [1:0] MODE_CLIP = 2'd0;
  localparam logic [1:0] MODE_SQ   = 2'd1;
  localparam logic [1:0] MODE_DIST = 2'd2;
  localparam logic [1:0] MODE_OFS  = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       view_we;
    logic       proj_we;
    logic [3:0] view_addr;
    logic [3:0] proj_addr;
    logic       beat;
    logic [1:0] mode;
    logic       first;
    logic [1:0] sel_idx;
    logic       clip_store;
    logic       clip_sel;
    logic       sub;
    logic [1:0] co_j;
    logic       sqrt_start;
    logic       div_start;
    logic [1:0] div_j;
    logic       plane_we;
    logic [4:0] plane_addr;
  } fsc_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic len_zero;
    logic acc_le0;
  } fsc_stat_t;

endpackage

FILE: rtl/frustum_sphere_cull_unit.sv
`timescale 1ns / 1ps
// frustum sphere culling unit
// input channel: a beat is taken when start is high and busy is low
//   op 0 / 1 writes elem_value into view / projection element elem_index
//   op 2 tests the sphere center_x/y/z with sphere_radius against the frustum
// result channel: done is high for one cycle with inside_res and culling_plane;
//   the receiver cannot stall, so results are never held back
// every accepted beat gives exactly one result
// loads and unused ops: result in the cycle after accept, busy stays low
// test with current planes: per plane the three distance products and the offset
//   term go through the multiplier pipeline and are summed; degenerate planes are skipped
// first test after a load also rebuilds the planes on the shared multiplier,
//   square root and divider: per plane the eight clip terms, the squared
//   length, its root and the divides that normalize the four coefficients
//   (skipped when the length is zero), then a step to the next plane
// reset clears the controller and marks the planes stale; both matrices must
//   be loaded before the first test
module frustum_sphere_cull_unit #(
  parameter int FRAC_BITS = fsc_pkg::FSC_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  output logic               done,
  output logic               inside_res,
  output logic [2:0]         culling_plane
);
  import fsc_pkg::*;

  fsc_cmd_t  cmd;
  fsc_stat_t stat;

  fsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .elem_index(elem_index),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done), .inside_res(inside_res),
    .culling_plane(culling_plane)
  );

  fsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .elem_value(elem_value),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius)
  );

`ifndef SYNTHESIS
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op != OP_TEST) |=> (done && !inside_res && culling_plane == PLANE_NONE))
    else $error("load beat without its result");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a beat in flight");

  a_inside_none: assert property (@(posedge clk) disable iff (rst)
    (done && inside_res) |-> (culling_plane == PLANE_NONE))
    else $error("inside result names a plane");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!cmd.view_we && !cmd.proj_we))
    else $error("matrix write during a test");
`endif

endmodule

FILE: rtl/fsc_ram.sv
`timescale 1ns / 1ps
module fsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fsc_ctrl.sv
`timescale 1ns / 1ps
module fsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic [3:0]        elem_index,
  input  fsc_pkg::fsc_stat_t stat,
  output fsc_pkg::fsc_cmd_t  cmd,
  output logic              busy,
  output logic              done,
  output logic              inside_res,
  output logic [2:0]        culling_plane
);
  import fsc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EX_MAC   = 4'd1;
  localparam logic [3:0] S_WAIT     = 4'd2;
  localparam logic [3:0] S_EX_STORE = 4'd3;
  localparam logic [3:0] S_SQ_MAC   = 4'd4;
  localparam logic [3:0] S_SQRT_GO  = 4'd5;
  localparam logic [3:0] S_SQRT_RUN = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_RUN  = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_T_MAC    = 4'd10;
  localparam logic [3:0] S_T_CHK    = 4'd11;

  logic [3:0] state, state_next, ret_state, ret_state_next;
  logic       wcnt, wcnt_next;
  logic [2:0] p, p_next;
  logic [1:0] j, j_next, k, k_next;
  logic       sel, sel_next;
  logic       stale, stale_next;
  logic [5:0] degen, degen_next;
  logic       done_next, inside_next;
  logic [2:0] plane_next;
  logic [1:0] col;
  logic       sub;

  assign busy = (state != S_IDLE);
  assign col  = sel ? p[2:1] : 2'd3;
  assign sub  = (p == 3'd0) || (p == 3'd3) || (p == 3'd4);

  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    wcnt_next      = wcnt;
    p_next         = p;
    j_next         = j;
    k_next         = k;
    sel_next       = sel;
    stale_next     = stale;
    degen_next     = degen;
    done_next      = 1'b0;
    inside_next    = 1'b0;
    plane_next     = PLANE_NONE;
    cmd            = '0;
    cmd.view_addr  = elem_index;
    cmd.proj_addr  = elem_index;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_VIEW: begin
              cmd.view_we = 1'b1;
              stale_next  = 1'b1;
              done_next   = 1'b1;
            end
            OP_PROJ: begin
              cmd.proj_we = 1'b1;
              stale_next  = 1'b1;
              done_next   = 1'b1;
            end
            OP_TEST: begin
              cmd.latch = 1'b1;
              p_next    = 3'd0;
              j_next    = 2'd0;
              k_next    = 2'd0;
              sel_next  = 1'b0;
              if (stale) begin
                degen_next = '0;
                state_next = S_EX_MAC;
              end else begin
                state_next = S_T_MAC;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_EX_MAC: begin
        cmd.beat      = 1'b1;
        cmd.mode      = MODE_CLIP;
        cmd.first     = (k == 2'd0);
        cmd.view_addr = {j, k};
        cmd.proj_addr = {k, col};
        k_next        = k + 2'd1;
        if (k == 2'd3) begin
          wcnt_next      = 1'b0;
          ret_state_next = S_EX_STORE;
          state_next     = S_WAIT;
        end
      end
      S_WAIT: begin
        wcnt_next = 1'b1;
        if (wcnt) begin
          wcnt_next  = 1'b0;
          state_next = ret_state;
        end
      end
      S_EX_STORE: begin
        cmd.clip_store = 1'b1;
        cmd.clip_sel   = sel;
        cmd.sub        = sub;
        cmd.co_j       = j;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = S_EX_MAC;
        end else begin
          sel_next = 1'b0;
          j_next   = j + 2'd1;
          if (j == 2'd3) begin
            state_next = S_SQ_MAC;
          end else begin
            state_next = S_EX_MAC;
          end
        end
      end
      S_SQ_MAC: begin
        cmd.beat    = 1'b1;
        cmd.mode    = MODE_SQ;
        cmd.first   = (j == 2'd0);
        cmd.sel_idx = j;
        j_next      = j + 2'd1;
        if (j == 2'd2) begin
          j_next         = 2'd0;
          wcnt_next      = 1'b0;
          ret_state_next = S_SQRT_GO;
          state_next     = S_WAIT;
        end
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT_RUN;
      end
      S_SQRT_RUN: begin
        if (!stat.sqrt_busy) begin
          if (stat.len_zero) begin
            degen_next[p] = 1'b1;
            state_next    = S_NEXT;
          end else begin
            j_next     = 2'd0;
            state_next = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_j     = j;
        state_next    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.plane_addr = {p, j};
        if (!stat.div_busy) begin
          cmd.plane_we = 1'b1;
          j_next       = j + 2'd1;
          if (j == 2'd3) begin
            state_next = S_NEXT;
          end else begin
            state_next = S_DIV_GO;
          end
        end
      end
      S_NEXT: begin
        j_next   = 2'd0;
        k_next   = 2'd0;
        sel_next = 1'b0;
        if (p == LAST_PLANE) begin
          p_next     = 3'd0;
          stale_next = 1'b0;
          state_next = S_T_MAC;
        end else begin
          p_next     = p + 3'd1;
          state_next = S_EX_MAC;
        end
      end
      S_T_MAC: begin
        if (degen[p]) begin
          if (p == LAST_PLANE) begin
            done_next   = 1'b1;
            inside_next = 1'b1;
            state_next  = S_IDLE;
          end else begin
            p_next = p + 3'd1;
          end
        end else begin
          cmd.beat       = 1'b1;
          cmd.mode       = (k == 2'd3) ? MODE_OFS : MODE_DIST;
          cmd.first      = (k == 2'd0);
          cmd.sel_idx    = k;
          cmd.plane_addr = {p, k};
          k_next         = k + 2'd1;
          if (k == 2'd3) begin
            wcnt_next      = 1'b0;
            ret_state_next = S_T_CHK;
            state_next     = S_WAIT;
          end
        end
      end
      S_T_CHK: begin
        if (stat.acc_le0) begin
          done_next  = 1'b1;
          plane_next = p;
          state_next = S_IDLE;
        end else if (p == LAST_PLANE) begin
          done_next   = 1'b1;
          inside_next = 1'b1;
          state_next  = S_IDLE;
        end else begin
          p_next     = p + 3'd1;
          state_next = S_T_MAC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ret_state     <= S_IDLE;
      wcnt          <= 1'b0;
      p             <= 3'd0;
      j             <= 2'd0;
      k             <= 2'd0;
      sel           <= 1'b0;
      stale         <= 1'b1;
      degen         <= '0;
      done          <= 1'b0;
      inside_res    <= 1'b0;
      culling_plane <= PLANE_NONE;
    end else begin
      state         <= state_next;
      ret_state     <= ret_state_next;
      wcnt          <= wcnt_next;
      p             <= p_next;
      j             <= j_next;
      k             <= k_next;
      sel           <= sel_next;
      stale         <= stale_next;
      degen         <= degen_next;
      done          <= done_next;
      inside_res    <= inside_next;
      culling_plane <= plane_next;
    end
  end

endmodule

FILE: rtl/fsc_dp.sv
`timescale 1ns / 1ps
module fsc_dp #(
  parameter int FRAC_BITS = fsc_pkg::FSC_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  fsc_pkg::fsc_cmd_t  cmd,
  output fsc_pkg::fsc_stat_t stat,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius
);
  import fsc_pkg::*;

  localparam int DW  = 32 + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [31:0] view_rd, proj_rd, plane_rd, norm_val;

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_view (
    .clk(clk), .we(cmd.view_we), .waddr(cmd.view_addr), .wdata(elem_value),
    .raddr(cmd.view_addr), .rdata(view_rd)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(16)) u_proj (
    .clk(clk), .we(cmd.proj_we), .waddr(cmd.proj_addr), .wdata(elem_value),
    .raddr(cmd.proj_addr), .rdata(proj_rd)
  );

  fsc_ram #(.WIDTH(32), .DEPTH(4 * NUM_PLANES)) u_plane (
    .clk(clk), .we(cmd.plane_we), .waddr(cmd.plane_addr), .wdata(norm_val),
    .raddr(cmd.plane_addr), .rdata(plane_rd)
  );

  logic signed [31:0] cx, cy, cz;
  logic [30:0]        rad;
  logic signed [31:0] co [4];
  logic signed [31:0] w_reg;

  logic        b1_valid, b2_valid, b1_first, b2_first;
  logic [1:0]  b1_mode, b2_mode, b1_sel;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul, ofs, prod;
  logic signed [65:0] term, acc;
  logic signed [31:0] acc_sat;
  logic signed [65:0] co_sum;

  always_comb begin
    case (b1_mode)
      MODE_CLIP: begin
        op_a = signed'(view_rd);
        op_b = signed'(proj_rd);
      end
      MODE_SQ: begin
        op_a = co[b1_sel];
        op_b = co[b1_sel];
      end
      MODE_DIST: begin
        op_a = signed'(plane_rd);
        case (b1_sel)
          2'd0:    op_b = cx;
          2'd1:    op_b = cy;
          default: op_b = cz;
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul  = op_a * op_b;
  assign ofs  = (64'(signed'(plane_rd)) + signed'(64'(rad))) <<< FRAC_BITS;
  assign term = (b2_mode == MODE_CLIP) ? 66'(prod >>> FRAC_BITS) : 66'(prod);
  assign acc_sat = sat32(acc);
  assign co_sum = cmd.sub ? (66'(w_reg) - 66'(acc_sat)) : (66'(w_reg) + 66'(acc_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= cmd.beat;
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    b1_mode  <= cmd.mode;
    b1_first <= cmd.first;
    b1_sel   <= cmd.sel_idx;
    b2_mode  <= b1_mode;
    b2_first <= b1_first;
    if (b1_valid) begin
      prod <= (b1_mode == MODE_OFS) ? ofs : mul;
    end
    if (b2_valid) begin
      acc <= b2_first ? term : acc + term;
    end
    if (cmd.latch) begin
      cx  <= center_x;
      cy  <= center_y;
      cz  <= center_z;
      rad <= sphere_radius;
    end
    if (cmd.clip_store) begin
      if (!cmd.clip_sel) begin
        w_reg <= acc_sat;
      end else begin
        co[cmd.co_j] <= sat32(co_sum);
      end
    end
  end

  // integer square root, two bits per step
  logic [63:0] sq_n, sq_res, sq_bit;
  logic        sq_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
    end else if (sq_busy && sq_bit == 64'd1) begin
      sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_n   <= acc[63:0];
      sq_res <= '0;
      sq_bit <= 64'd1 << 62;
    end else if (sq_busy) begin
      if (sq_n >= sq_res + sq_bit) begin
        sq_n   <= sq_n - (sq_res + sq_bit);
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DW-1:0]  dv_q;
  logic [32:0]    dv_rem, dv_shift;
  logic [DCW-1:0] dv_cnt;
  logic           dv_busy, dv_neg, dv_big;
  logic [31:0]    dv_mag, len;
  logic signed [31:0] dv_x;

  assign len      = sq_res[31:0];
  assign dv_x     = co[cmd.div_j];
  assign dv_mag   = dv_x[31] ? (~dv_x + 32'd1) : dv_x;
  assign dv_shift = {dv_rem[31:0], dv_q[DW-1]};
  assign dv_big   = |dv_q[DW-1:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && dv_cnt == DCW'(1)) begin
      dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_neg <= dv_x[31];
      dv_q   <= {dv_mag, {FRAC_BITS{1'b0}}};
      dv_rem <= '0;
      dv_cnt <= DCW'(DW);
    end else if (dv_busy) begin
      if (dv_shift >= {1'b0, len}) begin
        dv_rem <= dv_shift - {1'b0, len};
        dv_q   <= {dv_q[DW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_shift;
        dv_q   <= {dv_q[DW-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - DCW'(1);
    end
  end

  always_comb begin
    if (dv_big) begin
      norm_val = dv_neg ? 32'h80000000 : 32'h7fffffff;
    end else begin
      norm_val = dv_neg ? (~dv_q[31:0] + 32'd1) : dv_q[31:0];
    end
  end

  assign stat.sqrt_busy = sq_busy;
  assign stat.div_busy  = dv_busy;
  assign stat.len_zero  = (len == 32'd0);
  assign stat.acc_le0   = acc[65] || (acc == '0);

endmodule

FILE: tb/frustum_sphere_cull_checker.sv
`timescale 1ns / 1ps
module frustum_sphere_cull_checker
  import fsc_pkg::*;
#(
  parameter int FB = FSC_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         op,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  input  logic               done,
  input  logic               inside_res,
  input  logic [2:0]         culling_plane,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic       visible;
    logic [2:0] plane;
  } verdict_t;

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic signed [31:0] planes [24];
  logic [5:0]         degen;
  logic               stale;
  verdict_t           verdict_q [$];

  assign pending = verdict_q.size();

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] normalize(logic signed [31:0] x, logic [63:0] len);
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] sq;
    mag = (x < 0) ? 64'(-(64'(x))) : 64'(x);
    q = (mag << FB) / len;
    if (q > 64'd2147483648) q = 64'd2147483648;
    sq = (x < 0) ? -$signed(q) : $signed(q);
    return sat32(sq);
  endfunction

  task automatic rebuild_planes();
    logic signed [31:0] clip [16];
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [31:0] co [4];
    logic signed [63:0] w;
    logic signed [63:0] e;
    logic [63:0]        ss;
    logic [63:0]        len;
    int                 axis;
    logic               sub;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(view_m[r*4+k]) * 64'(proj_m[k*4+c]);
          acc = acc + (prod >>> FB);
        end
        clip[r*4+c] = sat32(acc);
      end
    degen = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      axis = p >> 1;
      sub = (p == 0 || p == 3 || p == 4);
      for (int j = 0; j < 4; j++) begin
        w = 64'(clip[4*j+3]);
        e = 64'(clip[4*j+axis]);
        co[j] = sat32(sub ? w - e : w + e);
      end
      ss = 0;
      for (int j = 0; j < 3; j++) ss = ss + 64'(64'(co[j]) * 64'(co[j]));
      len = int_sqrt(ss);
      for (int j = 0; j < 4; j++) planes[p*4+j] = (len == 0) ? 32'sd0 : normalize(co[j], len);
      if (len == 0) degen[p] = 1'b1;
    end
    stale = 1'b0;
  endtask

  task automatic predict_beat();
    verdict_t           v;
    logic signed [63:0] dist_sum;
    logic signed [63:0] rlim;
    v.visible = 1'b0;
    v.plane = PLANE_NONE;
    case (op)
      OP_VIEW: begin
        view_m[elem_index] = elem_value;
        stale = 1'b1;
      end
      OP_PROJ: begin
        proj_m[elem_index] = elem_value;
        stale = 1'b1;
      end
      OP_TEST: begin
        if (stale) rebuild_planes();
        rlim = -(64'(sphere_radius) <<< FB);
        v.visible = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
          if (!degen[p] && v.visible) begin
            dist_sum = 64'(planes[p*4]) * 64'(center_x) + 64'(planes[p*4+1]) * 64'(center_y)
                     + 64'(planes[p*4+2]) * 64'(center_z) + (64'(planes[p*4+3]) <<< FB);
            if (dist_sum <= rlim) begin
              v.visible = 1'b0;
              v.plane = 3'(p);
            end
          end
        end
      end
      default: ;
    endcase
    verdict_q.push_back(v);
  endtask

  initial begin
    fail_count = 0;
    degen = '0;
    stale = 1'b1;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = 0;
      proj_m[i] = 0;
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (inside_res !== v.visible) begin
            $error("inside_res expected %0d actual %0d", v.visible, inside_res);
            fail_count++;
          end
          if (culling_plane !== v.plane) begin
            $error("culling_plane expected %0d actual %0d", v.plane, culling_plane);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_beat();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fsc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1800;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         op;
  logic [3:0]         elem_index;
  logic signed [31:0] elem_value;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic               done;
  logic               inside_res;
  logic [2:0]         culling_plane;
  int                 fail_count;
  int                 pending;
  int                 quiet_cycles;
  logic               allow_gaps;

  frustum_sphere_cull_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .elem_index(elem_index), .elem_value(elem_value), .center_x(center_x),
    .center_y(center_y), .center_z(center_z), .sphere_radius(sphere_radius),
    .done(done), .inside_res(inside_res), .culling_plane(culling_plane)
  );

  frustum_sphere_cull_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .elem_index(elem_index), .elem_value(elem_value), .center_x(center_x),
    .center_y(center_y), .center_z(center_z), .sphere_radius(sphere_radius),
    .done(done), .inside_res(inside_res), .culling_plane(culling_plane),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      2: return 32'sh00010000;
      default: return $signed(32'($urandom_range(0, 32'h80000))) - 32'sh40000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $signed(32'($urandom_range(0, 32'h200000))) - 32'sh100000;
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return 31'($urandom());
      1: return 0;
      default: return 31'($urandom_range(0, 32'h60000));
    endcase
  endfunction

  task automatic send(input logic [1:0] o, input logic [3:0] idx, input logic signed [31:0] val,
                      input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [31:0] z, input logic [30:0] r);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    elem_index <= idx;
    elem_value <= val;
    center_x <= x;
    center_y <= y;
    center_z <= z;
    sphere_radius <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic load(input logic [1:0] o, input logic [3:0] idx, input logic signed [31:0] val);
    send(o, idx, val, rand_coord(), rand_coord(), rand_coord(), rand_radius());
  endtask

  task automatic test_sphere(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic [30:0] r);
    send(OP_TEST, 4'($urandom()), $urandom(), x, y, z, r);
  endtask

  task automatic load_matrix(input logic [1:0] o, input logic signed [31:0] diag);
    for (int i = 0; i < 16; i++) load(o, 4'(i), (i % 5 == 0) ? diag : 32'sd0);
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    op = OP_VIEW;
    elem_index = '0;
    elem_value = '0;
    center_x = '0;
    center_y = '0;
    center_z = '0;
    sphere_radius = '0;
    quiet_cycles = 0;
    allow_gaps = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero matrices: every plane degenerate
    load_matrix(OP_VIEW, 32'sd0);
    load_matrix(OP_PROJ, 32'sd0);
    test_sphere(32'sh7fffffff, 32'sh80000000, 32'sd0, 31'h7fffffff);
    // identity frustum: unit cube
    load_matrix(OP_VIEW, 32'sh00010000);
    load_matrix(OP_PROJ, 32'sh00010000);
    test_sphere(0, 0, 0, 0);
    test_sphere(32'sh00020000, 0, 0, 0);
    test_sphere(32'sh00020000, 0, 0, 31'h00010000);
    test_sphere(32'sh00010000, 0, 0, 0);
    test_sphere(32'shfffe0000, 0, 0, 0);
    test_sphere(0, 32'sh00030000, 0, 0);
    test_sphere(0, 32'shfffd0000, 0, 0);
    test_sphere(0, 0, 32'sh00030000, 0);
    test_sphere(0, 0, 32'shfffd0000, 0);
    test_sphere(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
    send(OP_UNUSED, 4'hf, 32'sh7fffffff, 0, 0, 0, 0);
    // extreme elements saturate the planes
    load(OP_VIEW, 4'd0, 32'sh7fffffff);
    load(OP_PROJ, 4'd15, 32'sh80000000);
    load(OP_VIEW, 4'd15, 32'shffffffff);
    test_sphere(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    test_sphere(0, 0, 0, 31'h7fffffff);

    n = 0;
    while (n < RANDOM_BEATS) begin
      if (n > RANDOM_BEATS - 200) allow_gaps = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < 16; i++) load(OP_VIEW, 4'(i), rand_elem());
          for (int i = 0; i < 16; i++) load(OP_PROJ, 4'(i), rand_elem());
          n += 32;
        end
        1: begin
          load($urandom_range(0, 1) ? OP_VIEW : OP_PROJ, 4'($urandom()), rand_elem());
          n++;
        end
        2: begin
          send(OP_UNUSED, 4'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
               31'($urandom()));
          n++;
        end
        default: begin
          repeat ($urandom_range(1, 8)) test_sphere(rand_coord(), rand_coord(), rand_coord(),
                                                    rand_radius());
          n += 4;
        end
      endcase
    end
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
